// ----- rtl/core/hcbp_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the Huffman code bit packer.
// No dependencies; imported by every module of the block.
package hcbp_pkg;

    // Port field widths
    localparam int CMD_W   = 2;
    localparam int SYM_W   = 8;
    localparam int CODE_W  = 32;
    localparam int LEN_W   = 6;
    localparam int BYTE_W  = 8;
    localparam int BITS_W  = 4;
    localparam int TOTAL_W = 40;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

    // Back end sequencer states
    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } t_bk_state;

endpackage

// ----- rtl/core/huffman_code_bit_packer.sv -----
`timescale 1ns / 1ps
// Huffman code bit packer: command input channel, packed byte output channel.
// Usage:
//   Input transfers carry a command: load writes a code table entry (no result),
//   encode looks up a symbol and packs its codeword MSB first into bytes, flush
//   emits the partial byte right aligned with the saturating bit total.
//   Each result is one output transfer; o_last marks the final one of a command.
// Path: a result passes through the lookup register, the queue and the back end;
//   after the first byte of an encode, later bytes follow one per cycle while the
//   receiver does not stall. The back end first merges each encode's codeword,
//   then emits its bytes, or parks the leftover bits when no byte fills; a flush
//   emits the accumulator; loads and unknown commands never reach the back end.
//   A four-entry queue decouples table lookup from byte emission.
// Reset (synchronous, active low) clears the accumulator, pending count, bit
//   total and the queue; the code table is not cleared and must be loaded
//   before a symbol is encoded.
// When the receiver stalls, the output register holds its result; the queue
//   fills, and o_in_stall rises only when the lookup stage cannot drain.
module huffman_code_bit_packer #(
    parameter int NUM_SYMBOLS  = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [hcbp_pkg::CMD_W-1:0]    i_command,
    input  logic [hcbp_pkg::SYM_W-1:0]    i_symbol,
    input  logic [hcbp_pkg::CODE_W-1:0]   i_code_bits,
    input  logic [hcbp_pkg::LEN_W-1:0]    i_code_length,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [hcbp_pkg::BYTE_W-1:0]   o_out_byte,
    output logic [hcbp_pkg::BITS_W-1:0]   o_byte_bits,
    output logic [hcbp_pkg::TOTAL_W-1:0]  o_total_bits,
    output logic                          o_last
);
    import hcbp_pkg::*;

    localparam int LW     = $clog2(MAX_CODE_LEN + 1);
    localparam int DATA_W = 1 + MAX_CODE_LEN + LW;

    logic              push;
    logic [DATA_W-1:0] push_data;
    logic              q_full;
    logic              q_valid;
    logic [DATA_W-1:0] q_data;
    logic              pop;

    hcbp_front #(
        .NUM_SYMBOLS  (NUM_SYMBOLS),
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .LW           (LW),
        .DATA_W       (DATA_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_symbol      (i_symbol),
        .i_code_bits   (i_code_bits),
        .i_code_length (i_code_length),
        .o_push        (push),
        .o_push_data   (push_data),
        .i_q_full      (q_full)
    );

    hcbp_fifo #(
        .DATA_W (DATA_W),
        .DEPTH  (4)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (pop)
    );

    hcbp_back #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .LW           (LW),
        .DATA_W       (DATA_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ent_valid  (q_valid),
        .i_ent_data   (q_data),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_byte_bits  (o_byte_bits),
        .o_total_bits (o_total_bits),
        .o_last       (o_last)
    );

endmodule

// ----- rtl/core/hcbp_front.sv -----
`timescale 1ns / 1ps
// Front end: takes command transfers, owns the code table memory,
// and hands encode/flush work to the queue. Depends on hcbp_pkg.
module hcbp_front #(
    parameter int NUM_SYMBOLS  = 256,
    parameter int MAX_CODE_LEN = 32,
    parameter int LW           = 6,
    parameter int DATA_W       = 39
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [hcbp_pkg::CMD_W-1:0]    i_command,
    input  logic [hcbp_pkg::SYM_W-1:0]    i_symbol,
    input  logic [hcbp_pkg::CODE_W-1:0]   i_code_bits,
    input  logic [hcbp_pkg::LEN_W-1:0]    i_code_length,
    output logic                          o_push,
    output logic [DATA_W-1:0]             o_push_data,
    input  logic                          i_q_full
);
    import hcbp_pkg::*;

    localparam int IDX_W = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;

    logic [MAX_CODE_LEN-1:0] r_code_mem [NUM_SYMBOLS];
    logic [LW-1:0]           r_len_mem  [NUM_SYMBOLS];

    logic                    r_s1_valid;
    logic                    r_s1_flush;
    logic                    r_s1_oor;
    logic [MAX_CODE_LEN-1:0] r_rd_code;
    logic [LW-1:0]           r_rd_len;

    logic                    accept;
    logic                    in_range;
    logic [IDX_W-1:0]        idx;
    logic [LW-1:0]           clamp_len;
    logic                    is_load;
    logic                    is_work;

    // Transfer control: hold off only while a finished item cannot enter the queue
    assign o_in_stall = r_s1_valid & i_q_full;
    assign accept     = i_in_valid & ~o_in_stall;
    assign o_push     = r_s1_valid & ~i_q_full;

    assign in_range  = {1'b0, i_symbol} < (SYM_W + 1)'(NUM_SYMBOLS);
    assign idx       = i_symbol[IDX_W-1:0];
    assign is_load   = (i_command == CMD_LOAD);
    assign is_work   = (i_command == CMD_ENCODE) || (i_command == CMD_FLUSH);
    assign clamp_len = (i_code_length > LEN_W'(MAX_CODE_LEN)) ?
                       LW'(MAX_CODE_LEN) : i_code_length[LW-1:0];

    // Table write on load, registered read on encode
    always_ff @(posedge i_clk) begin
        if (accept && is_load && in_range) begin
            r_code_mem[idx] <= i_code_bits[MAX_CODE_LEN-1:0];
            r_len_mem[idx]  <= clamp_len;
        end
        if (accept && (i_command == CMD_ENCODE)) begin
            r_rd_code <= r_code_mem[idx];
            r_rd_len  <= r_len_mem[idx];
        end
        if (accept) begin
            r_s1_flush <= (i_command == CMD_FLUSH);
            r_s1_oor   <= ~in_range;
        end
    end

    // Lookup stage occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= is_work;
        end else if (o_push) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Queue entry: {flush, codeword, length}; out-of-range symbols encode empty
    assign o_push_data = {r_s1_flush, r_rd_code,
                          (r_s1_oor || r_s1_flush) ? LW'(0) : r_rd_len};

endmodule

// ----- rtl/core/hcbp_fifo.sv -----
`timescale 1ns / 1ps
// Small synchronous queue between the front and back ends.
// Imports hcbp_pkg but uses none of its items; depth must be a power of two.
module hcbp_fifo #(
    parameter int DATA_W = 39,
    parameter int DEPTH  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data,
    input  logic              i_pop
);
    import hcbp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PW-1:0]     r_wr_ptr;
    logic [PW-1:0]     r_rd_ptr;
    logic [PW:0]       r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == (PW + 1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/core/hcbp_back.sv -----
`timescale 1ns / 1ps
// Back end: merges codewords into the byte accumulator, emits full bytes one per cycle
// while the output is free, handles flush and holds the output register. Uses hcbp_pkg.
module hcbp_back #(
    parameter int MAX_CODE_LEN = 32,
    parameter int LW           = 6,
    parameter int DATA_W       = 39
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_ent_valid,
    input  logic [DATA_W-1:0]             i_ent_data,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [hcbp_pkg::BYTE_W-1:0]   o_out_byte,
    output logic [hcbp_pkg::BITS_W-1:0]   o_byte_bits,
    output logic [hcbp_pkg::TOTAL_W-1:0]  o_total_bits,
    output logic                          o_last
);
    import hcbp_pkg::*;

    localparam int WIN = MAX_CODE_LEN + BYTE_W;
    localparam int CW  = $clog2(WIN);

    // Saturating total update
    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                   input logic [BITS_W-1:0] b);
        logic [TOTAL_W:0] sum;
        sum = {1'b0, a} + (TOTAL_W + 1)'(b);
        return sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
    endfunction

    t_bk_state               r_state, n_state;
    logic [WIN-1:0]          r_val, n_val;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic [BYTE_W-1:0]       r_acc, n_acc;
    logic [2:0]              r_pend, n_pend;
    logic [TOTAL_W-1:0]      r_total, n_total;

    logic                    r_o_valid, n_o_valid;
    logic [BYTE_W-1:0]       r_o_byte, n_o_byte;
    logic [BITS_W-1:0]       r_o_bits, n_o_bits;
    logic [TOTAL_W-1:0]      r_o_total, n_o_total;
    logic                    r_o_last, n_o_last;

    logic                    ent_flush;
    logic [MAX_CODE_LEN-1:0] ent_code;
    logic [LW-1:0]           ent_len;
    logic                    out_free;
    logic [WIN-1:0]          merged;
    logic [CW-1:0]           rem;
    logic [BYTE_W-1:0]       emit_byte;
    logic [TOTAL_W-1:0]      tot_flush;
    logic [TOTAL_W-1:0]      tot_byte;

    assign ent_flush = i_ent_data[DATA_W-1];
    assign ent_code  = i_ent_data[LW +: MAX_CODE_LEN];
    assign ent_len   = i_ent_data[LW-1:0];
    assign out_free  = ~r_o_valid | ~i_out_stall;

    // Pending bits followed by the codeword, right aligned
    assign merged    = (WIN'(r_acc) << ent_len) |
                       (WIN'(ent_code) & ~({WIN{1'b1}} << ent_len));
    assign rem       = r_cnt - CW'(BYTE_W);
    assign emit_byte = BYTE_W'(r_val >> rem);
    assign tot_flush = sat_add(r_total, BITS_W'(r_pend));
    assign tot_byte  = sat_add(r_total, BITS_W'(BYTE_W));

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_val     <= '0;
            r_cnt     <= '0;
            r_acc     <= '0;
            r_pend    <= '0;
            r_total   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_val     <= n_val;
            r_cnt     <= n_cnt;
            r_acc     <= n_acc;
            r_pend    <= n_pend;
            r_total   <= n_total;
            r_o_valid <= n_o_valid;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        r_o_byte  <= n_o_byte;
        r_o_bits  <= n_o_bits;
        r_o_total <= n_o_total;
        r_o_last  <= n_o_last;
    end

    // Next state and result generation
    always_comb begin
        n_state   = r_state;
        n_val     = r_val;
        n_cnt     = r_cnt;
        n_acc     = r_acc;
        n_pend    = r_pend;
        n_total   = r_total;
        n_o_valid = r_o_valid & i_out_stall;
        n_o_byte  = r_o_byte;
        n_o_bits  = r_o_bits;
        n_o_total = r_o_total;
        n_o_last  = r_o_last;
        o_pop     = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_ent_valid) begin
                    if (ent_flush) begin
                        if (out_free) begin
                            o_pop     = 1'b1;
                            n_total   = tot_flush;
                            n_o_valid = 1'b1;
                            n_o_byte  = r_acc;
                            n_o_bits  = BITS_W'(r_pend);
                            n_o_total = tot_flush;
                            n_o_last  = 1'b1;
                            n_acc     = '0;
                            n_pend    = '0;
                        end
                    end else begin
                        o_pop   = 1'b1;
                        n_val   = merged;
                        n_cnt   = CW'(r_pend) + CW'(ent_len);
                        n_state = BK_EMIT;
                    end
                end
            end
            BK_EMIT: begin
                if (r_cnt < CW'(BYTE_W)) begin
                    // leftover bits go back to the accumulator
                    n_acc   = r_val[BYTE_W-1:0] & ~({BYTE_W{1'b1}} << r_cnt);
                    n_pend  = r_cnt[2:0];
                    n_state = BK_IDLE;
                end else if (out_free) begin
                    n_total   = tot_byte;
                    n_o_valid = 1'b1;
                    n_o_byte  = emit_byte;
                    n_o_bits  = BITS_W'(BYTE_W);
                    n_o_total = tot_byte;
                    n_o_last  = (rem < CW'(BYTE_W));
                    n_cnt     = rem;
                    if (rem < CW'(BYTE_W)) begin
                        n_acc   = r_val[BYTE_W-1:0] & ~({BYTE_W{1'b1}} << rem);
                        n_pend  = rem[2:0];
                        n_state = BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    assign o_out_valid  = r_o_valid;
    assign o_out_byte   = r_o_byte;
    assign o_byte_bits  = r_o_bits;
    assign o_total_bits = r_o_total;
    assign o_last       = r_o_last;

endmodule
